/* hw/rtl/pbd_pkg.sv */
`default_nettype none

package pbd_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_CHANNELS      = 32;
  localparam int unsigned DEF_COUNTER_WIDTH = 8;

  // Fixed field widths of the streams and the configuration port.
  localparam int unsigned SAMPLE_W    = 32;
  localparam int unsigned THR_BYTE_W  = 8;
  localparam int unsigned THR_PER_REG = 8;
  localparam int unsigned NUM_REGS    = 4;
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = THR_BYTE_W * THR_PER_REG;

  // Register indexes of the threshold words.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_THR_0_7   = 8'd0,
    REG_THR_8_15  = 8'd1,
    REG_THR_16_23 = 8'd2,
    REG_THR_24_31 = 8'd3
  } reg_index_t;

  // What one lane reports for the sample currently offered.
  typedef struct packed {
    logic stable_next;
    logic flip;
  } lane_out_t;

  // One result: stable bits in the low half, changed mask in the high half.
  typedef struct packed {
    logic [SAMPLE_W-1:0] changed_bits;
    logic [SAMPLE_W-1:0] stable_bits;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/per_bit_counter_debouncer_core.sv */
`default_nettype none

// Per-bit counter debouncer for up to 32 contact inputs.
// The sample stream (s_tvalid/s_tready/s_tdata) carries one 32-bit raw
// sample per transaction, bit i being channel i. Each channel has its own
// lane holding a debounced bit and a counter; all lanes update in the same
// cycle a sample is accepted, so the block takes one sample every cycle
// while s_tready is high. The result stream (m_tvalid/m_tready/m_tdata)
// carries the debounced bits and a mask of the bits that flipped on that
// sample, one per sample, each registered before it reaches m_tvalid.
// Results sit in a two-entry output buffer: when the receiver stalls, one
// more sample is still accepted into the skid entry, and s_tready then drops
// until the receiver takes a result. Throughput is bounded only by the
// per-lane compare and increment, so sustained rate is one transaction per
// cycle whenever the receiver keeps m_tready high.
// Thresholds are written through the configuration channel, which is always
// ready; register i holds the eight thresholds of channels 8i to 8i+7, one
// per byte. Writes to indexes beyond the list are ignored.
// Synchronous reset clears all thresholds, debounced bits, counters and the
// output buffer; the block accepts samples in the first cycle after reset.

module per_bit_counter_debouncer_core
  import pbd_pkg::*;
#(
  parameter int unsigned CHANNELS      = DEF_CHANNELS,
  parameter int unsigned COUNTER_WIDTH = DEF_COUNTER_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Sample stream. s_tdata: raw_bits[31:0].
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [SAMPLE_W-1:0]    s_tdata,
  // Result stream. m_tdata: stable_bits[31:0], changed_bits[63:32].
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [2*SAMPLE_W-1:0]       m_tdata,
  // Configuration write channel.
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [CFG_DATA_W-1:0] thr_regs [NUM_REGS];
  lane_out_t             lanes    [CHANNELS];
  result_t               result;
  logic                  accept;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid & s_tready;

  // Threshold registers; a write to an unknown index changes nothing.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        thr_regs[r] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_THR_0_7:   thr_regs[0] <= cfg_data;
        REG_THR_8_15:  thr_regs[1] <= cfg_data;
        REG_THR_16_23: thr_regs[2] <= cfg_data;
        REG_THR_24_31: thr_regs[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // One lane per channel. Channels past the register set get threshold zero,
  // and channels past the sample word see a raw bit of zero.
  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
    logic [COUNTER_WIDTH-1:0] threshold;
    logic                     raw;

    if (ch / THR_PER_REG < NUM_REGS) begin : g_thr
      logic [THR_BYTE_W-1:0] thr_byte;
      assign thr_byte =
        thr_regs[ch / THR_PER_REG][(ch % THR_PER_REG) * THR_BYTE_W +: THR_BYTE_W];
      if (COUNTER_WIDTH <= THR_BYTE_W) begin : g_cut
        assign threshold = thr_byte[COUNTER_WIDTH-1:0];
      end else begin : g_ext
        assign threshold = {{(COUNTER_WIDTH - THR_BYTE_W){1'b0}}, thr_byte};
      end
    end else begin : g_zero
      assign threshold = '0;
    end

    if (ch < SAMPLE_W) begin : g_raw
      assign raw = s_tdata[ch];
    end else begin : g_noraw
      assign raw = 1'b0;
    end

    pbd_lane #(
      .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_lane (
      .clk      (clk),
      .rst      (rst),
      .en       (accept),
      .raw      (raw),
      .threshold(threshold),
      .lane_out (lanes[ch])
    );
  end

  pbd_merge #(
    .CHANNELS(CHANNELS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_ready(s_tready),
    .lanes     (lanes),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (result)
  );

  assign m_tdata = result;

endmodule

`default_nettype wire

/* hw/rtl/pbd_lane.sv */
`default_nettype none

module pbd_lane
  import pbd_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = DEF_COUNTER_WIDTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     raw,
  input  wire logic [COUNTER_WIDTH-1:0] threshold,
  output lane_out_t                     lane_out
);

  logic                     stable;
  logic [COUNTER_WIDTH-1:0] count;
  logic                     stable_next;
  logic [COUNTER_WIDTH-1:0] count_next;
  logic                     differ;
  logic                     hit;

  assign differ = raw ^ stable;
  assign hit    = (count == threshold);

  // A differing bit is taken over once its count has reached the threshold;
  // a matching bit leaves its partial count alone.
  always_comb begin
    stable_next = stable;
    count_next  = count;
    if (differ) begin
      if (hit) begin
        stable_next = raw;
        count_next  = '0;
      end else begin
        count_next = count + COUNTER_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable <= 1'b0;
      count  <= '0;
    end else if (en) begin
      stable <= stable_next;
      count  <= count_next;
    end
  end

  assign lane_out.stable_next = stable_next;
  assign lane_out.flip        = differ & hit;

endmodule

`default_nettype wire

/* hw/rtl/pbd_merge.sv */
`default_nettype none

module pbd_merge
  import pbd_pkg::*;
#(
  parameter int unsigned CHANNELS = DEF_CHANNELS
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  output logic           push_ready,
  input  wire lane_out_t lanes [CHANNELS],
  output logic           out_valid,
  input  wire logic      out_ready,
  output result_t        out_data
);

  result_t merged;
  result_t main_data;
  result_t skid_data;
  logic    main_valid;
  logic    skid_valid;
  logic    pop;

  // Only the lanes that fall inside the sample word reach the result.
  for (genvar i = 0; i < SAMPLE_W; i++) begin : g_pack
    if (i < CHANNELS) begin : g_lane
      assign merged.stable_bits[i]  = lanes[i].stable_next;
      assign merged.changed_bits[i] = lanes[i].flip;
    end else begin : g_none
      assign merged.stable_bits[i]  = 1'b0;
      assign merged.changed_bits[i] = 1'b0;
    end
  end

  assign pop        = main_valid & out_ready;
  assign push_ready = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_data <= skid_data;
      end else if (push) begin
        main_data <= merged;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_data <= merged;
      end else begin
        main_data <= merged;
      end
    end
  end

  assign out_valid = main_valid;
  assign out_data  = main_data;

endmodule

`default_nettype wire
